/* src/assert_macros.svh */
// Assertion macros shared by the broadcast index generator RTL.
// A module that uses them must have i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, checked out of reset.
`define BCIDX_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Condition that must never be true at a clock edge.
`define BCIDX_ASSERT_NEVER(lbl, cond, msg) \
    `BCIDX_ASSERT(lbl, !(cond), msg)

`endif

/* src/bcidx_pkg.sv */
// Package for the broadcast index generator: sizes, codes and shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bcidx_pkg;

    localparam int NUM_DIMS    = 4;
    localparam int DIM_BITS    = 12;
    localparam int DATA_W      = 48;
    localparam int STRIDE_W    = DIM_BITS * (NUM_DIMS - 1);
    localparam int PROD_W      = STRIDE_W + DIM_BITS;
    localparam int CFG_IDX_W   = 2;
    localparam int LEAD_STAGES = NUM_DIMS + 1;
    localparam int DIV_STAGES  = (NUM_DIMS - 1) * DIM_BITS;
    localparam int PAIRS       = (NUM_DIMS + 1) / 2;

    localparam logic [CFG_IDX_W-1:0] REG_LHS_SHAPE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_RHS_SHAPE = CFG_IDX_W'(1);

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INCOMPAT = 2'd1;
    localparam logic [1:0] ST_BEYOND   = 2'd2;

    typedef logic [DIM_BITS-1:0] t_dim;
    typedef logic [DATA_W-1:0]   t_word;
    typedef logic [1:0]          t_status;

    typedef struct packed {
        logic [NUM_DIMS-1:0][DIM_BITS-1:0] od;
        logic [NUM_DIMS-1:0][STRIDE_W-1:0] out_stride;
        logic [NUM_DIMS-1:0][STRIDE_W-1:0] lhs_stride;
        logic [NUM_DIMS-1:0][STRIDE_W-1:0] rhs_stride;
        t_word                             total;
        t_word                             out_shape;
        logic                              ok;
    } t_shape_info;

    typedef struct packed {
        t_status                           status;
        t_word                             rem;
        logic [NUM_DIMS-1:0][DIM_BITS-1:0] idx;
    } t_div_item;

    localparam t_dim DIM_ONE = t_dim'(1);

    function automatic t_word ones_shape();
        t_word v;
        v = '0;
        for (int i = 0; i < NUM_DIMS; i++) begin
            if ((i + 1) * DIM_BITS <= DATA_W) begin
                v[i * DIM_BITS] = 1'b1;
            end
        end
        return v;
    endfunction

endpackage

`default_nettype wire

/* src/bcidx_shape.sv */
// Shape registers and the derived broadcast shape, element count and strides.
// Depends on bcidx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bcidx_shape import bcidx_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire t_word                i_cfg_data,
    output t_shape_info               o_info
);

    t_word r_lhs_shape;
    t_word r_rhs_shape;

    logic [NUM_DIMS-1:0][DIM_BITS-1:0] r_od,     n_od;
    logic [NUM_DIMS-1:0]               r_a_one,  n_a_one;
    logic [NUM_DIMS-1:0]               r_b_one,  n_b_one;
    logic                              r_ok,     n_ok;
    t_word                             r_oshape, n_oshape;

    t_word               r_os [1:NUM_DIMS];
    logic [STRIDE_W-1:0] r_as [1:NUM_DIMS-1];
    logic [STRIDE_W-1:0] r_bs [1:NUM_DIMS-1];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lhs_shape <= ones_shape();
            r_rhs_shape <= ones_shape();
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_LHS_SHAPE: r_lhs_shape <= i_cfg_data;
                REG_RHS_SHAPE: r_rhs_shape <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        t_dim a;
        t_dim b;
        n_ok     = 1'b1;
        n_od     = '0;
        n_oshape = '0;
        n_a_one  = '0;
        n_b_one  = '0;
        for (int i = 0; i < NUM_DIMS; i++) begin
            a = r_lhs_shape[i*DIM_BITS +: DIM_BITS];
            b = r_rhs_shape[i*DIM_BITS +: DIM_BITS];
            n_a_one[i] = (a == DIM_ONE);
            n_b_one[i] = (b == DIM_ONE);
            if (a == b || b == DIM_ONE) begin
                n_od[i] = a;
            end else if (a == DIM_ONE) begin
                n_od[i] = b;
            end else begin
                n_od[i] = '0;
                n_ok    = 1'b0;
            end
            n_oshape[i*DIM_BITS +: DIM_BITS] = n_od[i];
        end
    end

    always_ff @(posedge i_clk) begin
        r_od     <= n_od;
        r_a_one  <= n_a_one;
        r_b_one  <= n_b_one;
        r_ok     <= n_ok;
        r_oshape <= n_oshape;
    end

    // running products of the dims, one multiply per register
    for (genvar gi = 1; gi <= NUM_DIMS; gi++) begin : g_chain
        logic [STRIDE_W-1:0] os_base;
        logic [PROD_W-1:0]   os_prod;

        if (gi == 1) begin : g_first
            assign os_base = STRIDE_W'(1);
        end else begin : g_next
            assign os_base = r_os[gi-1][STRIDE_W-1:0];
        end

        assign os_prod = os_base * r_od[gi-1];

        always_ff @(posedge i_clk) begin
            r_os[gi] <= DATA_W'(os_prod);
        end

        if (gi < NUM_DIMS) begin : g_opnd
            logic [STRIDE_W-1:0] as_base, bs_base;
            logic [PROD_W-1:0]   as_prod, bs_prod;

            if (gi == 1) begin : g_first
                assign as_base = STRIDE_W'(1);
                assign bs_base = STRIDE_W'(1);
            end else begin : g_next
                assign as_base = r_as[gi-1];
                assign bs_base = r_bs[gi-1];
            end

            assign as_prod = as_base * r_lhs_shape[(gi-1)*DIM_BITS +: DIM_BITS];
            assign bs_prod = bs_base * r_rhs_shape[(gi-1)*DIM_BITS +: DIM_BITS];

            always_ff @(posedge i_clk) begin
                r_as[gi] <= as_prod[STRIDE_W-1:0];
                r_bs[gi] <= bs_prod[STRIDE_W-1:0];
            end
        end
    end

    always_comb begin
        o_info.od            = r_od;
        o_info.ok            = r_ok;
        o_info.out_shape     = r_oshape;
        o_info.total         = r_os[NUM_DIMS];
        o_info.out_stride[0] = STRIDE_W'(1);
        o_info.lhs_stride[0] = r_a_one[0] ? '0 : STRIDE_W'(1);
        o_info.rhs_stride[0] = r_b_one[0] ? '0 : STRIDE_W'(1);
        for (int i = 1; i < NUM_DIMS; i++) begin
            o_info.out_stride[i] = r_os[i][STRIDE_W-1:0];
            o_info.lhs_stride[i] = r_a_one[i] ? '0 : r_as[i];
            o_info.rhs_stride[i] = r_b_one[i] ? '0 : r_bs[i];
        end
    end

endmodule

`default_nettype wire

/* src/bcidx_divider.sv */
// Lead-in stages, status check and the pipelined restoring divider that
// splits a linear position into per-dimension indices. Depends on bcidx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bcidx_divider import bcidx_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire t_word       i_pos,
    input  wire t_shape_info i_info,
    output logic             o_valid,
    output t_div_item        o_item
);

    logic [LEAD_STAGES-1:0] r_lead_valid;
    t_word                  r_lead_pos [LEAD_STAGES];
    logic [DIV_STAGES-1:0]  r_div_valid;
    t_div_item              r_div_item [DIV_STAGES];
    t_div_item              div_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead_valid <= '0;
            r_div_valid  <= '0;
        end else if (i_en) begin
            r_lead_valid <= {r_lead_valid[LEAD_STAGES-2:0], i_valid};
            r_div_valid  <= {r_div_valid[DIV_STAGES-2:0], r_lead_valid[LEAD_STAGES-1]};
        end
    end

    // lead-in gives the shape products time to settle after a config write
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lead_pos[0] <= i_pos;
            for (int i = 1; i < LEAD_STAGES; i++) begin
                r_lead_pos[i] <= r_lead_pos[i-1];
            end
        end
    end

    always_comb begin
        div_in.rem = r_lead_pos[LEAD_STAGES-1];
        div_in.idx = '0;
        if (!i_info.ok) begin
            div_in.status = ST_INCOMPAT;
        end else if (r_lead_pos[LEAD_STAGES-1] >= i_info.total) begin
            div_in.status = ST_BEYOND;
        end else begin
            div_in.status = ST_OK;
        end
    end

    // outer dim first, one quotient bit per stage
    for (genvar gj = 0; gj < DIV_STAGES; gj++) begin : g_div
        localparam int DIM = NUM_DIMS - 1 - gj / DIM_BITS;
        localparam int BIT = DIM_BITS - 1 - gj % DIM_BITS;

        t_div_item prev;
        t_div_item next;
        t_word     divisor;

        if (gj == 0) begin : g_head
            assign prev = div_in;
        end else begin : g_tail
            assign prev = r_div_item[gj-1];
        end

        assign divisor = DATA_W'(i_info.out_stride[DIM]) << BIT;

        always_comb begin
            next = prev;
            if (prev.rem >= divisor) begin
                next.rem           = prev.rem - divisor;
                next.idx[DIM][BIT] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_div_item[gj] <= next;
            end
        end
    end

    assign o_valid = r_div_valid[DIV_STAGES-1];
    assign o_item  = r_div_item[DIV_STAGES-1];

endmodule

`default_nettype wire

/* src/bcidx_accum.sv */
// Operand index assembly: stride multiplies, adder tree, status masking and
// the output register. Depends on bcidx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bcidx_accum import bcidx_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire t_div_item   i_item,
    input  wire t_shape_info i_info,
    output logic             o_valid,
    output t_status          o_status,
    output t_word            o_lhs_index,
    output t_word            o_rhs_index,
    output t_word            o_out_shape
);

    logic [NUM_DIMS-1:0][DIM_BITS-1:0] idx;

    logic    r_p_valid, r_s_valid, r_o_valid;
    t_status r_p_status, r_s_status, r_o_status;
    t_word   r_lhs_prod [NUM_DIMS];
    t_word   r_rhs_prod [NUM_DIMS];
    t_word   r_lhs_pair [PAIRS];
    t_word   r_rhs_pair [PAIRS];
    t_word   r_o_lhs, r_o_rhs, r_o_shape;
    t_word   n_o_lhs, n_o_rhs;

    always_comb begin
        idx    = i_item.idx;
        idx[0] = i_item.rem[DIM_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_s_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (i_en) begin
            r_p_valid <= i_valid;
            r_s_valid <= r_p_valid;
            r_o_valid <= r_s_valid;
        end
    end

    for (genvar gi = 0; gi < NUM_DIMS; gi++) begin : g_mul
        logic [PROD_W-1:0] lhs_prod, rhs_prod;

        assign lhs_prod = idx[gi] * i_info.lhs_stride[gi];
        assign rhs_prod = idx[gi] * i_info.rhs_stride[gi];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_lhs_prod[gi] <= DATA_W'(lhs_prod);
                r_rhs_prod[gi] <= DATA_W'(rhs_prod);
            end
        end
    end

    for (genvar gp = 0; gp < PAIRS; gp++) begin : g_pair
        t_word lhs_hi, rhs_hi;

        if (2 * gp + 1 < NUM_DIMS) begin : g_two
            assign lhs_hi = r_lhs_prod[2*gp+1];
            assign rhs_hi = r_rhs_prod[2*gp+1];
        end else begin : g_one
            assign lhs_hi = '0;
            assign rhs_hi = '0;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_lhs_pair[gp] <= r_lhs_prod[2*gp] + lhs_hi;
                r_rhs_pair[gp] <= r_rhs_prod[2*gp] + rhs_hi;
            end
        end
    end

    always_comb begin
        t_word lhs_sum;
        t_word rhs_sum;
        lhs_sum = '0;
        rhs_sum = '0;
        for (int p = 0; p < PAIRS; p++) begin
            lhs_sum = lhs_sum + r_lhs_pair[p];
            rhs_sum = rhs_sum + r_rhs_pair[p];
        end
        n_o_lhs = (r_s_status == ST_OK) ? lhs_sum : '0;
        n_o_rhs = (r_s_status == ST_OK) ? rhs_sum : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_status <= i_item.status;
            r_s_status <= r_p_status;
            r_o_status <= r_s_status;
            r_o_lhs    <= n_o_lhs;
            r_o_rhs    <= n_o_rhs;
            r_o_shape  <= (r_s_status == ST_INCOMPAT) ? '0 : i_info.out_shape;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_status    = r_o_status;
    assign o_lhs_index = r_o_lhs;
    assign o_rhs_index = r_o_rhs;
    assign o_out_shape = r_o_shape;

endmodule

`default_nettype wire

/* src/broadcast_index_generator_top.sv */
// Top level of the broadcast index generator: handshake and pipeline enable.
// Depends on bcidx_pkg, bcidx_shape, bcidx_divider, bcidx_accum and assert_macros.svh.
//
//   channel  direction  handshake                  payload
//   cfg      in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//   in       in         i_in_valid  / o_in_stall   i_out_position
//   out      out        o_out_valid / i_out_stall  o_lhs_index, o_rhs_index,
//                                                  o_out_shape, o_status
//
// One transaction per cycle in and out while the output is not stalled.
// Most stages are in the restoring divider: one quotient bit per stage for each
// of the three outer dims (36 stages), plus 5 lead-in and 3 index stages.
// Reset loads both shapes with all dims 1 and clears every valid bit.
// A stalled output freezes the whole pipeline; o_in_stall follows it.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module broadcast_index_generator_top import bcidx_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire t_word                i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_word                i_out_position,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_word                     o_lhs_index,
    output t_word                     o_rhs_index,
    output t_word                     o_out_shape,
    output t_status                   o_status
);

    logic        pipe_en;
    t_shape_info info;
    logic        div_valid;
    t_div_item   div_item;

    assign pipe_en    = !(o_out_valid && i_out_stall);
    assign o_in_stall = !pipe_en;

    bcidx_shape u_shape (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_info      (info)
    );

    bcidx_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (i_in_valid),
        .i_pos   (i_out_position),
        .i_info  (info),
        .o_valid (div_valid),
        .o_item  (div_item)
    );

    bcidx_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (pipe_en),
        .i_valid     (div_valid),
        .i_item      (div_item),
        .i_info      (info),
        .o_valid     (o_out_valid),
        .o_status    (o_status),
        .o_lhs_index (o_lhs_index),
        .o_rhs_index (o_rhs_index),
        .o_out_shape (o_out_shape)
    );

    `BCIDX_ASSERT_NEVER(a_status_code, o_out_valid && o_status != ST_OK && o_status != ST_INCOMPAT && o_status != ST_BEYOND, "illegal status code on output")
    `BCIDX_ASSERT(a_err_zero_index, (o_out_valid && o_status != ST_OK) |-> (o_lhs_index == '0 && o_rhs_index == '0), "nonzero index on error transaction")
    `BCIDX_ASSERT(a_incompat_shape, (o_out_valid && o_status == ST_INCOMPAT) |-> (o_out_shape == '0), "shape reported for incompatible operands")

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for broadcast_index_generator_top.
// Depends on bcidx_pkg and the RTL under src; predicts every transaction
// from its own broadcast-indexing model and checks results in order.
`timescale 1ns / 1ps

module testbench;
    import bcidx_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int TAIL_CYCLES    = 60;

    typedef struct packed {
        t_word   lhs_index;
        t_word   rhs_index;
        t_word   out_shape;
        t_status status;
    } t_bcast_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    t_word                i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_word                i_out_position;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_word                o_lhs_index;
    t_word                o_rhs_index;
    t_word                o_out_shape;
    t_status              o_status;

    t_word         lhs_shape_reg;
    t_word         rhs_shape_reg;
    t_bcast_result pending_results[$];
    t_bcast_result want;
    int            mismatch_count = 0;
    int            src_idle_pct   = 0;
    int            sink_stall_pct = 0;
    int            hold_remaining = 0;
    int            quiet_cycles   = 0;

    broadcast_index_generator_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_out_position (i_out_position),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_lhs_index    (o_lhs_index),
        .o_rhs_index    (o_rhs_index),
        .o_out_shape    (o_out_shape),
        .o_status       (o_status)
    );

    always #1 i_clk = ~i_clk;

    function automatic t_word pack_dims(int d0, int d1, int d2, int d3);
        return {t_dim'(d3), t_dim'(d2), t_dim'(d1), t_dim'(d0)};
    endfunction

    function automatic t_word rand_word();
        return t_word'({$urandom(), $urandom()});
    endfunction

    function automatic t_bcast_result predict_broadcast(t_word pos, t_word lhs, t_word rhs);
        logic [63:0]   lhs_dim [NUM_DIMS];
        logic [63:0]   rhs_dim [NUM_DIMS];
        logic [63:0]   out_dim [NUM_DIMS];
        logic [63:0]   total;
        logic [63:0]   rem;
        logic [63:0]   digit;
        logic [63:0]   lhs_acc;
        logic [63:0]   rhs_acc;
        logic [63:0]   lhs_step;
        logic [63:0]   rhs_step;
        bit            compat;
        t_bcast_result r;
        r = '0;
        total = 64'd1;
        compat = 1'b1;
        for (int i = 0; i < NUM_DIMS; i++) begin
            lhs_dim[i] = 64'(lhs[i*DIM_BITS +: DIM_BITS]);
            rhs_dim[i] = 64'(rhs[i*DIM_BITS +: DIM_BITS]);
            if (lhs_dim[i] == rhs_dim[i] || rhs_dim[i] == 64'd1) begin
                out_dim[i] = lhs_dim[i];
            end else if (lhs_dim[i] == 64'd1) begin
                out_dim[i] = rhs_dim[i];
            end else begin
                out_dim[i] = 64'd0;
                compat = 1'b0;
            end
            r.out_shape[i*DIM_BITS +: DIM_BITS] = out_dim[i][DIM_BITS-1:0];
            // four 12-bit dims never overflow 64 bits
            total = total * out_dim[i];
        end
        if (!compat) begin
            r.out_shape = '0;
            r.status = ST_INCOMPAT;
            return r;
        end
        if (64'(pos) >= total) begin
            r.status = ST_BEYOND;
            return r;
        end
        rem = 64'(pos);
        lhs_acc = '0;
        rhs_acc = '0;
        lhs_step = 64'd1;
        rhs_step = 64'd1;
        for (int i = 0; i < NUM_DIMS; i++) begin
            digit = rem % out_dim[i];
            rem = rem / out_dim[i];
            if (lhs_dim[i] != 64'd1) lhs_acc = lhs_acc + digit * lhs_step;
            if (rhs_dim[i] != 64'd1) rhs_acc = rhs_acc + digit * rhs_step;
            lhs_step = lhs_step * lhs_dim[i];
            rhs_step = rhs_step * rhs_dim[i];
        end
        r.lhs_index = t_word'(lhs_acc);
        r.rhs_index = t_word'(rhs_acc);
        r.status = ST_OK;
        return r;
    endfunction

    // mostly in range, some just past the end, some anywhere
    function automatic t_word pick_position(t_word shape);
        logic [63:0] count;
        int          roll;
        count = 64'd1;
        for (int i = 0; i < NUM_DIMS; i++) begin
            count = count * 64'(shape[i*DIM_BITS +: DIM_BITS]);
        end
        roll = $urandom_range(99);
        if (count != 0 && roll < 85) return t_word'(64'(rand_word()) % count);
        if (roll < 93) return t_word'(count + 64'($urandom_range(3)));
        return rand_word();
    endfunction

    function automatic int rand_dim();
        int roll;
        roll = $urandom_range(9);
        if (roll < 7) return $urandom_range(6, 1);
        if (roll < 9) return $urandom_range(64, 1);
        return $urandom_range(4095, 1);
    endfunction

    task automatic random_compatible(output t_word lhs, output t_word rhs);
        int d;
        lhs = '0;
        rhs = '0;
        for (int i = 0; i < NUM_DIMS; i++) begin
            d = rand_dim();
            lhs[i*DIM_BITS +: DIM_BITS] = ($urandom_range(2) == 0) ? DIM_ONE : t_dim'(d);
            rhs[i*DIM_BITS +: DIM_BITS] = ($urandom_range(2) == 0) ? DIM_ONE : t_dim'(d);
        end
    endtask

    task automatic report_mismatch(input string what, input t_word got, input t_word exp_val);
        $display("%0t ERROR %s: got 0x%012h, want 0x%012h", $time, what, got, exp_val);
        mismatch_count++;
    endtask

    task automatic send_position(input t_word pos);
        t_bcast_result exp_res;
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_out_position <= pos;
        do @(posedge i_clk); while (o_in_stall);
        exp_res = predict_broadcast(pos, lhs_shape_reg, rhs_shape_reg);
        pending_results.insert(pending_results.size(), exp_res);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_transaction(input logic [CFG_IDX_W-1:0] idx, input t_word data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_LHS_SHAPE: lhs_shape_reg = data;
            REG_RHS_SHAPE: rhs_shape_reg = data;
            default: ;
        endcase
    endtask

    // every result is back before the shapes change
    task automatic configure_shapes(input t_word lhs, input t_word rhs, input bit poke_spare);
        drain_results();
        cfg_transaction(REG_LHS_SHAPE, lhs);
        if (poke_spare) begin
            cfg_transaction(REG_SPARE_2, rand_word());
            cfg_transaction(REG_SPARE_3, '1);
        end
        cfg_transaction(REG_RHS_SHAPE, rhs);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_shapes();
        send_position('0);
        send_position(t_word'(1));
        send_position('1);
    endtask

    task automatic test_broadcast_rules();
        t_word full_count;
        full_count = t_word'(64'd4095 * 64'd4095 * 64'd4095 * 64'd4095);
        configure_shapes(pack_dims(5, 1, 3, 1), pack_dims(1, 4, 3, 2), 1'b1);
        send_position('0);
        send_position(t_word'(1));
        send_position(t_word'(57));
        send_position(t_word'(119));
        send_position(t_word'(120));
        configure_shapes('1, '1, 1'b0);
        send_position(full_count - 1);
        send_position('0);
        send_position(full_count);
        send_position('1);
        // zero dim pairs with zero, count becomes zero
        configure_shapes(pack_dims(0, 3, 1, 1), pack_dims(0, 1, 1, 1), 1'b0);
        send_position('0);
        send_position(t_word'(5));
        configure_shapes(pack_dims(2, 1, 1, 1), pack_dims(3, 1, 1, 1), 1'b0);
        send_position('0);
        send_position('1);
        configure_shapes('0, '0, 1'b0);
        send_position('0);
        send_position(t_word'(1));
    endtask

    task automatic test_random_shapes();
        int            src_pct [4] = '{0, 78, 0, 37};
        int            sink_pct[4] = '{0, 0, 78, 37};
        t_word         lhs;
        t_word         rhs;
        t_word         shape;
        t_bcast_result pred;
        for (int m = 0; m < 4; m++) begin
            for (int s = 0; s < 4; s++) begin
                if (s == 3) begin
                    lhs = rand_word();
                    rhs = rand_word();
                end else begin
                    random_compatible(lhs, rhs);
                end
                configure_shapes(lhs, rhs, 1'b0);
                src_idle_pct = src_pct[m];
                sink_stall_pct = sink_pct[m];
                pred = predict_broadcast('0, lhs, rhs);
                shape = pred.out_shape;
                repeat (80) send_position(pick_position(shape));
            end
        end
    endtask

    task automatic test_output_backpressure();
        t_word         lhs;
        t_word         rhs;
        t_word         shape;
        t_bcast_result pred;
        random_compatible(lhs, rhs);
        configure_shapes(lhs, rhs, 1'b0);
        src_idle_pct = 0;
        sink_stall_pct = 0;
        pred = predict_broadcast('0, lhs, rhs);
        shape = pred.out_shape;
        hold_remaining = HOLD_CYCLES;
        repeat (100) send_position(pick_position(shape));
    endtask

    always @(posedge i_clk) begin
        if (hold_remaining > 0) begin
            i_out_stall <= 1'b1;
            hold_remaining = hold_remaining - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no pending transaction", o_lhs_index, '0);
            end else begin
                want = pending_results.pop_front();
                if (o_lhs_index !== want.lhs_index)
                    report_mismatch("lhs_index", o_lhs_index, want.lhs_index);
                if (o_rhs_index !== want.rhs_index)
                    report_mismatch("rhs_index", o_rhs_index, want.rhs_index);
                if (o_out_shape !== want.out_shape)
                    report_mismatch("out_shape", o_out_shape, want.out_shape);
                if (o_status !== want.status)
                    report_mismatch("status", t_word'(o_status), t_word'(want.status));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_out_position = '0;
        lhs_shape_reg = pack_dims(1, 1, 1, 1);
        rhs_shape_reg = pack_dims(1, 1, 1, 1);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_shapes();
        test_broadcast_rules();
        test_random_shapes();
        test_output_backpressure();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
